// File: design/lspe_pkg.sv
// ----------------------------------------------------------------------------
// lspe_pkg: shared types and constants of the line sensor position estimator
// Item structs, operation and register codes, controller states, and the
// fixed sizes of the sensor array and of the calibration arithmetic.
// ----------------------------------------------------------------------------
package lspe_pkg;

  // Sensor array size and ADC resolution
  localparam int unsigned CHANNELS    = 16;
  localparam int unsigned SAMPLE_BITS = 10;

  localparam logic [SAMPLE_BITS-1:0] SampleMax = '1;
  localparam logic [SAMPLE_BITS-1:0] ThrReset  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [3:0]             ChLast    = 4'(CHANNELS - 1);

  // range * (100 - sensitivity), then floor(x / 100) by reciprocal multiply
  localparam int unsigned ProdW      = SAMPLE_BITS + 7;
  localparam int unsigned RecipShift = 26;
  localparam int unsigned RecipW     = 20;
  localparam logic [RecipW-1:0] Recip100 = RecipW'((64'd1 << RecipShift) / 100 + 1);

  typedef enum logic [1:0] {
    OP_RUN  = 2'd0,
    OP_CAL  = 2'd1,
    OP_FIN  = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_SENS  = 2'd0,
    CFG_WHITE = 2'd1,
    CFG_MASK  = 2'd2,
    CFG_NONE  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ACC,
    ST_DIV,
    ST_POS,
    ST_FRD,
    ST_FMUL,
    ST_FWR
  } state_e;

  typedef struct packed {
    op_e         operation;
    logic [3:0]  channel;
    logic [9:0]  sample;
    logic        scan_last;
  } in_item_t;

  typedef struct packed {
    logic [15:0]       sensor_pattern;
    logic signed [7:0] line_position;
    logic              line_lost;
  } out_item_t;

endpackage

// File: design/line_sensor_position_estimator.sv
// ----------------------------------------------------------------------------
// line_sensor_position_estimator: thresholded scan and line centroid
// Builds a per-channel bit pattern from reflectance samples and reports the
// weighted line position at the end of each scan; tracks calibration ranges.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one sample item per
//   transfer: run sample, calibration sample or finish calibration. Output
//   channel (out_valid_o/out_ready_i/out_data_o) carries one result per run
//   sample marked scan_last. Registers are to be written through cfg_we_i
//   only while idle; the block itself does not enforce this. Run and
//   calibration samples first read the channel's entry from the threshold or
//   min/max memory, then compare and write. A scan end adds serial
//   accumulation over the pattern, bit-serial division for the centroid and
//   a load of the output register. Finish calibration walks the channels,
//   each with a read, a multiply, then a reciprocal divide and write.
//   The result sits in an output register; while it waits, new samples are
//   still taken, and only the next scan end holds until the register frees.
//   Reset clears control state, the valid bits of both memories (so entries
//   read as threshold 512, min 1023, max 0), the scan bits and last position.
// ----------------------------------------------------------------------------
module line_sensor_position_estimator (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lspe_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lspe_pkg::out_item_t  out_data_o
);

  localparam int unsigned SB = lspe_pkg::SAMPLE_BITS;

  // Configuration registers
  logic [6:0]  sens_q;
  logic        white_q;
  logic [15:0] mask_q;

  // Controller and item
  lspe_pkg::state_e   state_q, state_d;
  lspe_pkg::in_item_t item_q;
  logic [3:0]         idx_q;

  // Memories and their registered read ports
  logic [SB-1:0]   thr_mem [lspe_pkg::CHANNELS];
  logic [2*SB-1:0] mm_mem  [lspe_pkg::CHANNELS];
  logic [15:0]     thr_valid_q, mm_valid_q;
  logic [SB-1:0]   thr_rd_q;
  logic [2*SB-1:0] mm_rd_q;
  logic            thr_rv_q, mm_rv_q;

  // Finish calibration datapath
  logic [lspe_pkg::ProdW-1:0] prod_q;
  logic [SB-1:0]              fmin_q;
  logic                       fupd_q;

  // Scan and centroid datapath
  logic [15:0]       scan_q;
  logic signed [6:0] sum_q;
  logic [4:0]        cnt_q;
  logic [5:0]        dvd_q, rem_q, quo_q;
  logic              neg_q;
  logic [2:0]        step_q;
  logic signed [7:0] last_pos_q;

  // Output register
  logic                out_valid_q;
  lspe_pkg::out_item_t out_q;

  // Control
  logic            in_fire, out_load;
  logic            rd_en;
  logic [3:0]      rd_addr;
  logic            thr_we, mm_we, mm_clr;
  logic [3:0]      wr_addr;
  logic [SB-1:0]   thr_wdata;
  logic [2*SB-1:0] mm_wdata;

  // Derived values
  logic            in_range;
  logic [SB-1:0]   smp, cur_thr, cur_min, cur_max, new_min, new_max;
  logic            run_on;
  logic [15:0]     vmask, pattern;
  logic            acc_hit;
  logic signed [4:0] weight;
  logic signed [6:0] sum_d;
  logic [4:0]        cnt_d;
  logic [5:0]        sum_abs;
  logic [5:0]        rem_sh;
  logic              rem_ge;
  logic [6:0]        sat_sens, factor;
  logic [SB-1:0]     range_v;
  logic [lspe_pkg::ProdW+lspe_pkg::RecipW-1:0] recip_prod;
  logic [9:0]        pmag_full;
  logic [7:0]        pmag;
  logic signed [7:0] pos;
  logic              lost;

  assign in_fire  = in_valid_i && in_ready_o;
  assign in_range = ({1'b0, item_q.channel} < 5'(lspe_pkg::CHANNELS));
  assign smp      = item_q.sample[SB-1:0];

  // Entries never written read as their reset values
  assign cur_thr = thr_rv_q ? thr_rd_q : lspe_pkg::ThrReset;
  assign cur_min = mm_rv_q ? mm_rd_q[2*SB-1:SB] : lspe_pkg::SampleMax;
  assign cur_max = mm_rv_q ? mm_rd_q[SB-1:0] : '0;
  assign new_min = (smp < cur_min) ? smp : cur_min;
  assign new_max = (smp > cur_max) ? smp : cur_max;
  assign run_on  = mask_q[item_q.channel] && (smp > cur_thr);

  // Valid channels in pattern bit order (channel i at bit 15-i)
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      vmask[15-i] = mask_q[i] && (i < lspe_pkg::CHANNELS);
    end
  end
  assign pattern = white_q ? ~(scan_q & vmask) : (scan_q & vmask);

  // Serial accumulation: ~idx is bit 15-idx; weights -8..-1 then 1..8
  assign acc_hit = pattern[~idx_q] && vmask[~idx_q];
  assign weight  = idx_q[3] ? ($signed({1'b0, idx_q}) - 5'sd7)
                            : ($signed({1'b0, idx_q}) - 5'sd8);
  assign sum_d   = acc_hit ? (sum_q + {{2{weight[4]}}, weight}) : sum_q;
  assign cnt_d   = acc_hit ? (cnt_q + 5'd1) : cnt_q;
  assign sum_abs = sum_d[6] ? 6'(-sum_d) : sum_d[5:0];

  // Restoring division step, one quotient bit a cycle
  assign rem_sh = {rem_q[4:0], dvd_q[5]};
  assign rem_ge = (rem_sh >= {1'b0, cnt_q});

  // Calibrated threshold arithmetic
  assign sat_sens   = (sens_q > 7'd100) ? 7'd100 : sens_q;
  assign factor     = 7'd100 - sat_sens;
  assign range_v    = cur_max - cur_min;
  assign recip_prod = (lspe_pkg::ProdW + lspe_pkg::RecipW)'(prod_q) *
                      (lspe_pkg::ProdW + lspe_pkg::RecipW)'(lspe_pkg::Recip100);

  // Position: (sum / cnt) * 100 / 8, truncated toward zero on the magnitude
  assign pmag_full = 10'(quo_q) * 10'd100;
  assign pmag      = {1'b0, pmag_full[9:3]};
  assign pos       = neg_q ? -$signed(pmag) : $signed(pmag);
  assign lost      = (cnt_q == 5'd0);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lspe_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = (in_data_i.operation == lspe_pkg::OP_FIN) ? lspe_pkg::ST_FRD
                                                              : lspe_pkg::ST_EXEC;
        end
      end
      lspe_pkg::ST_EXEC: begin
        if (item_q.operation == lspe_pkg::OP_RUN && item_q.scan_last) begin
          state_d = lspe_pkg::ST_ACC;
        end else begin
          state_d = lspe_pkg::ST_IDLE;
        end
      end
      lspe_pkg::ST_ACC: begin
        if (idx_q == lspe_pkg::ChLast) state_d = lspe_pkg::ST_DIV;
      end
      lspe_pkg::ST_DIV: begin
        if (step_q == 3'd5) state_d = lspe_pkg::ST_POS;
      end
      lspe_pkg::ST_POS: begin
        if (!out_valid_q || out_ready_i) state_d = lspe_pkg::ST_IDLE;
      end
      lspe_pkg::ST_FRD:  state_d = lspe_pkg::ST_FMUL;
      lspe_pkg::ST_FMUL: state_d = lspe_pkg::ST_FWR;
      lspe_pkg::ST_FWR: begin
        state_d = (idx_q == lspe_pkg::ChLast) ? lspe_pkg::ST_IDLE : lspe_pkg::ST_FRD;
      end
      default: state_d = lspe_pkg::ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = in_data_i.channel;
    thr_we     = 1'b0;
    mm_we      = 1'b0;
    mm_clr     = 1'b0;
    wr_addr    = item_q.channel;
    thr_wdata  = fmin_q + recip_prod[lspe_pkg::RecipShift +: SB];
    mm_wdata   = {new_min, new_max};
    out_load   = 1'b0;
    case (state_q)
      lspe_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        rd_en      = in_fire;
      end
      lspe_pkg::ST_EXEC: begin
        mm_we = (item_q.operation == lspe_pkg::OP_CAL) && in_range;
      end
      lspe_pkg::ST_POS: begin
        out_load = !out_valid_q || out_ready_i;
      end
      lspe_pkg::ST_FRD: begin
        rd_en   = 1'b1;
        rd_addr = idx_q;
      end
      lspe_pkg::ST_FWR: begin
        wr_addr = idx_q;
        thr_we  = fupd_q;
        mm_clr  = (idx_q == lspe_pkg::ChLast);
      end
      default: begin
      end
    endcase
  end

  // Threshold and min/max memories, registered reads
  always_ff @(posedge clk_i) begin
    if (thr_we) thr_mem[wr_addr] <= thr_wdata;
    if (mm_we) mm_mem[wr_addr] <= mm_wdata;
    if (rd_en) begin
      thr_rd_q <= thr_mem[rd_addr];
      mm_rd_q  <= mm_mem[rd_addr];
    end
  end

  // Memory valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_valid_q <= '0;
      mm_valid_q  <= '0;
      thr_rv_q    <= 1'b0;
      mm_rv_q     <= 1'b0;
    end else begin
      if (thr_we) thr_valid_q[wr_addr] <= 1'b1;
      if (mm_we) mm_valid_q[wr_addr] <= 1'b1;
      if (mm_clr) mm_valid_q <= '0;
      if (rd_en) begin
        thr_rv_q <= thr_valid_q[rd_addr];
        mm_rv_q  <= mm_valid_q[rd_addr];
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q  <= 7'd50;
      white_q <= 1'b0;
      mask_q  <= 16'hFFFF;
    end else if (cfg_we_i) begin
      case (lspe_pkg::cfg_idx_e'(cfg_index_i))
        lspe_pkg::CFG_SENS:  sens_q  <= cfg_wdata_i[6:0];
        lspe_pkg::CFG_WHITE: white_q <= cfg_wdata_i[0];
        lspe_pkg::CFG_MASK:  mask_q  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Control state, scan bits and last position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lspe_pkg::ST_IDLE;
      idx_q       <= '0;
      scan_q      <= '0;
      last_pos_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) idx_q <= '0;
      if ((state_q == lspe_pkg::ST_ACC && idx_q != lspe_pkg::ChLast) ||
          (state_q == lspe_pkg::ST_FWR)) begin
        idx_q <= idx_q + 4'd1;
      end
      if (state_q == lspe_pkg::ST_EXEC && item_q.operation == lspe_pkg::OP_RUN &&
          in_range) begin
        scan_q[~item_q.channel] <= run_on;
      end
      if (out_load) begin
        scan_q <= '0;
        if (!lost) last_pos_q <= pos;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) item_q <= in_data_i;
    // calibration range times (100 - sensitivity)
    if (state_q == lspe_pkg::ST_FMUL) begin
      fupd_q <= (cur_max >= cur_min);
      fmin_q <= cur_min;
      prod_q <= lspe_pkg::ProdW'(range_v) * lspe_pkg::ProdW'(factor);
    end
    // accumulation, then load the divider on the last channel
    if (state_q == lspe_pkg::ST_EXEC) begin
      sum_q <= '0;
      cnt_q <= '0;
    end
    if (state_q == lspe_pkg::ST_ACC) begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      if (idx_q == lspe_pkg::ChLast) begin
        dvd_q  <= sum_abs;
        neg_q  <= sum_d[6];
        rem_q  <= '0;
        quo_q  <= '0;
        step_q <= '0;
      end
    end
    if (state_q == lspe_pkg::ST_DIV) begin
      rem_q  <= rem_ge ? (rem_sh - {1'b0, cnt_q}) : rem_sh;
      quo_q  <= {quo_q[4:0], rem_ge};
      dvd_q  <= {dvd_q[4:0], 1'b0};
      step_q <= step_q + 3'd1;
    end
    if (out_load) begin
      out_q.sensor_pattern <= pattern;
      out_q.line_position  <= lost ? last_pos_q : pos;
      out_q.line_lost      <= lost;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Assertions
  a_mem_wr_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (thr_we || mm_we) |-> !in_ready_o)
    else $error("memory write while accepting input");

  a_lost_repeats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.line_lost) |-> (out_data_o.line_position == last_pos_q))
    else $error("lost line does not repeat last position");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.line_lost) |->
      (out_data_o.line_position <= 8'sd100 && out_data_o.line_position >= -8'sd100))
    else $error("line position out of range");

  a_found_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.line_lost) |-> (out_data_o.sensor_pattern != 16'd0))
    else $error("line found with empty pattern");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");

endmodule

// File: tb/lspe_checker.sv
// ----------------------------------------------------------------------------
// lspe_checker: scoreboard of the line sensor position estimator
// Watches the register port and both channels, keeps its own copy of the
// calibration tables and scan state, predicts every scan report from the
// accepted sample transfers, and compares each report transfer field by field.
// ----------------------------------------------------------------------------
module lspe_checker
  import lspe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  in_item_t   in_data_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  out_item_t  out_data_i,
  output int         fail_count_o,
  output int         pending_o
);

  // Shadow of the block's tables, scan state and registers
  logic [9:0]        thr_q [16];
  logic [9:0]        min_q [16];
  logic [9:0]        max_q [16];
  logic [15:0]       scan_q;
  logic signed [7:0] last_pos_q;
  logic [6:0]        sens_q;
  logic              white_q;
  logic [15:0]       mask_q;

  out_item_t expected_reports [$];

  // Apply one accepted sample transfer; push a report on a scan end
  task automatic track_sample(in_item_t it);
    int        chn;
    int        s;
    int        rng;
    int        sum;
    int        cnt;
    int        pos;
    logic [15:0] vmask;
    logic [15:0] pattern;
    out_item_t rep;
    chn = it.channel;
    case (it.operation)
      OP_CAL: begin
        if (it.sample < min_q[chn]) min_q[chn] = it.sample;
        if (it.sample > max_q[chn]) max_q[chn] = it.sample;
      end
      OP_FIN: begin
        s = (sens_q > 7'd100) ? 100 : int'(sens_q);
        for (int i = 0; i < 16; i++) begin
          // a channel never calibrated keeps its threshold
          if (max_q[i] >= min_q[i]) begin
            rng = int'(max_q[i]) - int'(min_q[i]);
            thr_q[i] = 10'(int'(min_q[i]) + (rng * (100 - s)) / 100);
          end
          min_q[i] = '1;
          max_q[i] = '0;
        end
      end
      OP_RUN: begin
        scan_q[15 - chn] = mask_q[chn] && (it.sample > thr_q[chn]);
        if (it.scan_last) begin
          for (int i = 0; i < 16; i++) vmask[15 - i] = mask_q[i];
          pattern = scan_q & vmask;
          if (white_q) pattern = ~pattern;
          sum = 0;
          cnt = 0;
          for (int i = 0; i < 16; i++) begin
            if (vmask[15 - i] && pattern[15 - i]) begin
              sum += (i < 8) ? i - 8 : i - 7;
              cnt++;
            end
          end
          rep.sensor_pattern = pattern;
          if (cnt == 0) begin
            // line lost: repeat the previous position
            rep.line_position = last_pos_q;
            rep.line_lost     = 1'b1;
          end else begin
            pos = ((sum / cnt) * 100) / 8;
            rep.line_position = 8'(pos);
            rep.line_lost     = 1'b0;
            last_pos_q        = 8'(pos);
          end
          expected_reports.push_back(rep);
          scan_q = '0;
        end
      end
      default: ;
    endcase
  endtask

  // Compare one report transfer with the oldest prediction
  task automatic check_report(out_item_t got);
    out_item_t want;
    if (expected_reports.size() == 0) begin
      $display("%0t: unexpected report pattern %04h position %0d lost %0b",
               $time, got.sensor_pattern, got.line_position, got.line_lost);
      fail_count_o++;
    end else begin
      want = expected_reports.pop_front();
      if (got.sensor_pattern !== want.sensor_pattern) begin
        $display("%0t: sensor_pattern expected %04h actual %04h",
                 $time, want.sensor_pattern, got.sensor_pattern);
        fail_count_o++;
      end
      if (got.line_position !== want.line_position) begin
        $display("%0t: line_position expected %0d actual %0d",
                 $time, want.line_position, got.line_position);
        fail_count_o++;
      end
      if (got.line_lost !== want.line_lost) begin
        $display("%0t: line_lost expected %0b actual %0b",
                 $time, want.line_lost, got.line_lost);
        fail_count_o++;
      end
    end
  endtask

  // Sample everything at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        thr_q[i] = ThrReset;
        min_q[i] = SampleMax;
        max_q[i] = '0;
      end
      scan_q       = '0;
      last_pos_q   = '0;
      sens_q       = 7'd50;
      white_q      = 1'b0;
      mask_q       = 16'hFFFF;
      expected_reports.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_report(out_data_i);
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_SENS:  sens_q  = cfg_wdata_i[6:0];
          CFG_WHITE: white_q = cfg_wdata_i[0];
          CFG_MASK:  mask_q  = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) track_sample(in_data_i);
      pending_o = expected_reports.size();
    end
  end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: top of the line sensor position estimator testbench
// Drives directed and random sample sequences (scans, calibration runs and
// noise) through several register settings with random idling on both
// channels; the checker predicts and compares the scan reports.
// ----------------------------------------------------------------------------
module tb;
  import lspe_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_wdata;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;

  int fail_count;
  int pending;
  int tx_max_gap = 14;
  int rx_max_gap = 14;
  bit hold_req   = 1'b0;
  int sent       = 0;

  line_sensor_position_estimator i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  lspe_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Run limit
  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Report receiver: random stalls per transfer, one long hold on request
  initial begin : receiver
    int gap;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        gap      = 400;
        hold_req = 1'b0;
      end else begin
        gap = (rx_max_gap > 0) ? $urandom_range(rx_max_gap, 0) : 0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // One sample transfer, after a random gap
  task automatic drive_item(op_e op, logic [3:0] ch, logic [9:0] smp, logic last);
    int gap;
    gap = (tx_max_gap > 0) ? $urandom_range(tx_max_gap, 0) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= in_item_t'{op, ch, smp, last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op != OP_NONE) sent++;
  endtask

  // Drop valid and wait until the block has drained
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic configure(logic [6:0] sens, logic white, logic [15:0] mask);
    drain();
    write_reg(CFG_SENS, 16'(sens));
    write_reg(CFG_WHITE, 16'(white));
    write_reg(CFG_MASK, mask);
  endtask

  // Samples biased toward the ends of the ADC range
  function automatic logic [9:0] pick_sample();
    case ($urandom_range(7, 0))
      0: return 10'd0;
      1: return 10'h3FF;
      default: return 10'($urandom_range(1023, 0));
    endcase
  endfunction

  // Stimulus
  initial begin : stimulus
    int target;
    int n;
    int r;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    rst_n     = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset thresholds, ends of the line, lost line
    drive_item(OP_RUN, 4'd0, 10'h3FF, 1'b1);
    drive_item(OP_RUN, 4'd15, 10'h3FF, 1'b1);
    drive_item(OP_RUN, 4'd5, 10'd0, 1'b1);
    drive_item(OP_RUN, 4'd7, 10'd512, 1'b1);
    // centered pair, then a truncating centroid
    drive_item(OP_RUN, 4'd7, 10'd600, 1'b0);
    drive_item(OP_RUN, 4'd8, 10'd600, 1'b1);
    drive_item(OP_RUN, 4'd0, 10'h3FF, 1'b0);
    drive_item(OP_RUN, 4'd1, 10'h3FF, 1'b0);
    drive_item(OP_RUN, 4'd15, 10'h3FF, 1'b1);
    // unused operation and scan_last on calibration do nothing
    drive_item(OP_NONE, 4'd9, 10'h2AA, 1'b1);
    drive_item(OP_CAL, 4'd3, 10'd100, 1'b1);
    drive_item(OP_CAL, 4'd3, 10'd900, 1'b0);
    drive_item(OP_CAL, 4'd15, 10'd0, 1'b0);
    drive_item(OP_CAL, 4'd15, 10'h3FF, 1'b0);
    drive_item(OP_FIN, 4'd0, 10'd0, 1'b0);
    drive_item(OP_RUN, 4'd3, 10'd501, 1'b0);
    drive_item(OP_RUN, 4'd15, 10'd511, 1'b1);

    // Directed: saturated sensitivity, white line, partial mask
    configure(7'd127, 1'b1, 16'h00FF);
    write_reg(CFG_NONE, 16'hFFFF);
    drive_item(OP_CAL, 4'd2, 10'd10, 1'b0);
    drive_item(OP_CAL, 4'd2, 10'd20, 1'b0);
    drive_item(OP_FIN, 4'd0, 10'd0, 1'b1);
    drive_item(OP_RUN, 4'd2, 10'd11, 1'b1);
    configure(7'd50, 1'b0, 16'h0000);
    drive_item(OP_RUN, 4'd4, 10'h3FF, 1'b1);

    // Random phases, each under its own register setting
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin configure(7'd0, 1'b0, 16'hFFFF); tx_max_gap = 14; rx_max_gap = 14; end
        1: begin
          configure(7'd100, 1'b1, 16'($urandom));
          tx_max_gap = 0;
          rx_max_gap = 14;
          hold_req   = 1'b1;
        end
        2: begin configure(7'd127, 1'b0, 16'h0000); tx_max_gap = 14; rx_max_gap = 0; end
        3: begin
          configure(7'($urandom_range(100, 0)), 1'($urandom), 16'h8001);
          tx_max_gap = 14;
          rx_max_gap = 14;
        end
        4: begin
          configure(7'($urandom), 1'($urandom), 16'($urandom));
          tx_max_gap = 0;
          rx_max_gap = 0;
        end
        default: begin configure(7'd50, 1'b0, 16'hFFFF); tx_max_gap = 14; rx_max_gap = 0; end
      endcase
      target = sent + 108;
      while (sent < target) begin
        r = $urandom_range(99, 0);
        if (r < 45) begin
          // full ordered scan
          for (int c = 0; c < 16; c++)
            drive_item(OP_RUN, 4'(c), pick_sample(), c == 15);
        end else if (r < 60) begin
          // short scan over random channels
          n = $urandom_range(6, 1);
          for (int k = 0; k < n; k++)
            drive_item(OP_RUN, 4'($urandom), pick_sample(), k == n - 1);
        end else if (r < 80) begin
          // calibration run, usually closed by a finish
          n = $urandom_range(10, 2);
          for (int k = 0; k < n; k++)
            drive_item(OP_CAL, 4'($urandom), pick_sample(), 1'($urandom));
          if ($urandom_range(4, 0) != 0)
            drive_item(OP_FIN, 4'($urandom), 10'($urandom), 1'($urandom));
        end else begin
          // noise: any field values
          n = $urandom_range(3, 1);
          for (int k = 0; k < n; k++)
            drive_item(op_e'($urandom_range(3, 0)), 4'($urandom), 10'($urandom),
                       1'($urandom));
        end
      end
    end

    // Drain and give the verdict
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/lspe_pkg.sv
design/line_sensor_position_estimator.sv
tb/lspe_checker.sv
tb/tb.sv
